FILE: hdl/mfs_pkg.sv
package mfs_pkg;

  localparam int unsigned DataW           = 8;
  localparam int unsigned LenW            = 16;
  localparam int unsigned SeqW            = 16;
  localparam int unsigned PayloadMaxDflt  = 95;
  localparam int unsigned InTdataW        = DataW + LenW;

  // Flag byte bit positions
  localparam int unsigned FlagEndBit   = 0;
  localparam int unsigned FlagStartBit = 1;

  // Byte slot within one frame: three header bytes, then payload
  typedef enum logic [3:0] {
    PhFlag    = 4'b0001,
    PhSeqHi   = 4'b0010,
    PhSeqLo   = 4'b0100,
    PhPayload = 4'b1000
  } hdr_phase_e;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
    logic             payload;
  } emit_t;

endpackage

FILE: hdl/mfs_frame_ctrl.sv
module mfs_frame_ctrl
  import mfs_pkg::*;
#(
  parameter int unsigned PAYLOAD_MAX = PayloadMaxDflt
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DataW-1:0] item_data_i,
  input  logic [LenW-1:0]  item_len_i,
  input  logic             advance_i,
  output emit_t            emit_o
);

  localparam int unsigned FillW = $clog2(PAYLOAD_MAX + 1);

  logic [SeqW-1:0]  seq_q, seq_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             first_q, first_d;
  hdr_phase_e       phase_q, phase_d;

  logic             open;
  logic [LenW-1:0]  rem_eff;
  logic [FillW-1:0] fill_eff;
  logic             first_eff;
  logic             frame_start;
  logic             hdr;
  logic [DataW-1:0] flag;
  logic             last;

  // A closed message takes its length from this byte; zero length counts as one
  assign open        = (rem_q != '0);
  assign rem_eff     = open ? rem_q : ((item_len_i == '0) ? LenW'(1) : item_len_i);
  assign fill_eff    = open ? fill_q : '0;
  assign first_eff   = open ? first_q : 1'b1;
  assign frame_start = (fill_eff == '0);
  assign hdr         = frame_start && (phase_q != PhPayload);

  always_comb begin
    flag               = '0;
    flag[FlagStartBit] = first_eff;
    flag[FlagEndBit]   = (rem_eff <= LenW'(PAYLOAD_MAX));
  end

  assign last = !hdr && ((rem_eff == LenW'(1)) || (fill_eff >= FillW'(PAYLOAD_MAX - 1)));

  always_comb begin
    emit_o.last    = last;
    emit_o.payload = !hdr;
    if (!hdr) begin
      emit_o.data = item_data_i;
    end else begin
      unique case (phase_q)
        PhFlag:  emit_o.data = flag;
        PhSeqHi: emit_o.data = seq_q[SeqW-1 -: DataW];
        PhSeqLo: emit_o.data = seq_q[DataW-1:0];
        default: emit_o.data = item_data_i;
      endcase
    end
  end

  always_comb begin
    seq_d   = seq_q;
    rem_d   = rem_q;
    fill_d  = fill_q;
    first_d = first_q;
    phase_d = phase_q;
    if (advance_i) begin
      if (hdr) begin
        unique case (phase_q)
          PhFlag:  phase_d = PhSeqHi;
          PhSeqHi: phase_d = PhSeqLo;
          PhSeqLo: phase_d = PhPayload;
          default: phase_d = PhFlag;
        endcase
      end else begin
        phase_d = PhFlag;
        rem_d   = rem_eff - LenW'(1);
        fill_d  = last ? '0 : fill_eff + FillW'(1);
        seq_d   = frame_start ? seq_q + SeqW'(1) : seq_q;
        first_d = (rem_eff == LenW'(1)) ? 1'b1 : (frame_start ? 1'b0 : first_eff);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= '0;
      rem_q   <= '0;
      fill_q  <= '0;
      first_q <= 1'b1;
      phase_q <= PhFlag;
    end else begin
      seq_q   <= seq_d;
      rem_q   <= rem_d;
      fill_q  <= fill_d;
      first_q <= first_d;
      phase_q <= phase_d;
    end
  end

endmodule

FILE: hdl/message_frame_segmenter_unit.sv
// Message frame segmenter. Message bytes enter one per beat on the slave
// stream; the message length rides along in every beat but is sampled only on
// the first byte of a message (a length of zero counts as one). The message is
// cut into frames of up to PAYLOAD_MAX payload bytes, and each frame goes out
// on the master stream as a flag byte (bit 1 start frame, bit 0 end frame),
// the 16-bit frame sequence number high byte first, then the payload, with
// tlast on the last payload byte of the frame. The sequence number counts up
// per frame and wraps at 16 bits. Rate: one master beat per cycle from a single
// output register while tready is high and a byte is held. A byte that opens a
// frame waits while the three header bytes go out first through the same output
// register, and the input holding register stays occupied meanwhile.
module message_frame_segmenter_unit
  import mfs_pkg::*;
#(
  parameter int unsigned PAYLOAD_MAX = PayloadMaxDflt
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InTdataW-1:0] s_axis_tdata_i,   // [7:0] data_byte, [23:8] message_length
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [DataW-1:0]    m_axis_tdata_o,   // [7:0] out_byte
  output logic                m_axis_tlast_o    // frame_last
);

  // Input holding register
  logic             hold_valid_q;
  logic [DataW-1:0] hold_data_q;
  logic [LenW-1:0]  hold_len_q;

  // Output register
  logic             out_valid_q;
  logic [DataW-1:0] out_data_q;
  logic             out_last_q;

  logic  s_accept;
  logic  advance;
  emit_t emit;

  // Advance one output byte whenever a byte is held and the output register is free or draining
  assign advance         = hold_valid_q && (!out_valid_q || m_axis_tready_i);
  // Take the next beat when empty or once the held byte's payload slot goes out
  assign s_axis_tready_o = !hold_valid_q || (advance && emit.payload);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  mfs_frame_ctrl #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_frame_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_data_i (hold_data_q),
    .item_len_i  (hold_len_q),
    .advance_i   (advance),
    .emit_o      (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (s_accept) begin
      hold_valid_q <= 1'b1;
    end else if (advance && emit.payload) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      hold_data_q <= s_axis_tdata_i[DataW-1:0];
      hold_len_q  <= s_axis_tdata_i[DataW +: LenW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= emit.data;
      out_last_q <= emit.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
